// File: hw/rtl/gw_pkg.sv
package gw_pkg;

    localparam int GW_MAX_VERTICES = 64;
    localparam int GW_MAX_EDGES    = 256;
    localparam int VERT_W          = 6;
    localparam int VC_W            = 7;

    typedef enum logic [1:0] {
        K_CLEAR = 2'd0,
        K_ADD   = 2'd1,
        K_BFS   = 2'd2,
        K_DFS   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_CLEAR     = 4'd2,
        OP_ADD_RD_A  = 4'd3,
        OP_ADD_WR_A  = 4'd4,
        OP_ADD_RD_B  = 4'd5,
        OP_ADD_WR_B  = 4'd6,
        OP_WALK_INIT = 4'd7,
        OP_Q_RD      = 4'd8,
        OP_HEAD_RD_Q = 4'd9,
        OP_PTR_HEAD  = 4'd10,
        OP_BFS_USE   = 4'd11,
        OP_DFS_USE   = 4'd12,
        OP_STK_RD    = 4'd13,
        OP_PTR_STK   = 4'd14
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    emit;
        logic    emit_pend;
        logic    emit_last;
        t_status emit_stat;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  range_err;
        logic  mem_full;
        logic  q_empty;
        logic  rear_room;
        logic  top_room;
        logic  top_one;
        logic  ptr_null;
        logic  nbr_ok;
        logic  out_free;
    } t_stat;

endpackage

// File: hw/rtl/gw_in_if.sv
interface gw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] first_vertex;
    logic [5:0] second_vertex;

    modport source (output valid, kind, first_vertex, second_vertex, input ready);
    modport sink   (input valid, kind, first_vertex, second_vertex, output ready);
endinterface

// File: hw/rtl/gw_out_if.sv
interface gw_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] vertex;
    logic [1:0] status;
    logic       last;

    modport source (output valid, vertex, status, last, input ready);
    modport sink   (input valid, vertex, status, last, output ready);
endinterface

// File: hw/rtl/gw_ram.sv
module gw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/gw_ctrl.sv
module gw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gw_pkg::t_stat i_stat,
    output gw_pkg::t_cmd  o_cmd
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_DEC    = 15'h0002,
        S_ADD_A  = 15'h0004,
        S_ADD_RB = 15'h0008,
        S_ADD_B  = 15'h0010,
        S_BQ     = 15'h0020,
        S_BQ_W   = 15'h0040,
        S_BH_W   = 15'h0080,
        S_BE     = 15'h0100,
        S_BE_W   = 15'h0200,
        S_DH_W   = 15'h0400,
        S_DL     = 15'h0800,
        S_DS_W   = 15'h1000,
        S_DE_W   = 15'h2000,
        S_FIN    = 15'h4000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.op        = gw_pkg::OP_NONE;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_pend = 1'b0;
        o_cmd.emit_last = 1'b0;
        o_cmd.emit_stat = gw_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = gw_pkg::OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.kind == gw_pkg::K_CLEAR) begin
                    if (i_stat.out_free) begin
                        o_cmd.op        = gw_pkg::OP_CLEAR;
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.range_err || (i_stat.kind == gw_pkg::K_ADD &&
                                                  i_stat.mem_full)) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_stat = i_stat.range_err ? gw_pkg::ST_RANGE
                                                           : gw_pkg::ST_FULL;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.kind == gw_pkg::K_ADD) begin
                    o_cmd.op = gw_pkg::OP_ADD_RD_A;
                    n_state  = S_ADD_A;
                end else begin
                    o_cmd.op = gw_pkg::OP_WALK_INIT;
                    n_state  = (i_stat.kind == gw_pkg::K_BFS) ? S_BQ : S_DH_W;
                end
            end
            S_ADD_A: begin
                o_cmd.op = gw_pkg::OP_ADD_WR_A;
                n_state  = S_ADD_RB;
            end
            S_ADD_RB: begin
                o_cmd.op = gw_pkg::OP_ADD_RD_B;
                n_state  = S_ADD_B;
            end
            S_ADD_B: begin
                if (i_stat.out_free) begin
                    o_cmd.op        = gw_pkg::OP_ADD_WR_B;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    // keep the second endpoint's head on the read port
                    o_cmd.op = gw_pkg::OP_ADD_RD_B;
                end
            end
            S_BQ: begin
                if (i_stat.q_empty) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = gw_pkg::OP_Q_RD;
                    n_state  = S_BQ_W;
                end
            end
            S_BQ_W: begin
                o_cmd.op = gw_pkg::OP_HEAD_RD_Q;
                n_state  = S_BH_W;
            end
            S_BH_W: begin
                o_cmd.op = gw_pkg::OP_PTR_HEAD;
                n_state  = S_BE;
            end
            S_BE: begin
                n_state = i_stat.ptr_null ? S_BQ : S_BE_W;
            end
            S_BE_W: begin
                if (!(i_stat.nbr_ok && i_stat.rear_room)) begin
                    o_cmd.op = gw_pkg::OP_BFS_USE;
                    n_state  = S_BE;
                end else if (i_stat.out_free) begin
                    // new vertex found: the held one goes out, not last
                    o_cmd.op        = gw_pkg::OP_BFS_USE;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_pend = 1'b1;
                    n_state         = S_BE;
                end
            end
            S_DH_W: begin
                o_cmd.op = gw_pkg::OP_PTR_HEAD;
                n_state  = S_DL;
            end
            S_DL: begin
                if (!i_stat.ptr_null) begin
                    n_state = S_DE_W;
                end else if (i_stat.top_one) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = gw_pkg::OP_STK_RD;
                    n_state  = S_DS_W;
                end
            end
            S_DS_W: begin
                o_cmd.op = gw_pkg::OP_PTR_STK;
                n_state  = S_DL;
            end
            S_DE_W: begin
                if (!(i_stat.nbr_ok && i_stat.top_room)) begin
                    o_cmd.op = gw_pkg::OP_DFS_USE;
                    n_state  = S_DL;
                end else if (i_stat.out_free) begin
                    o_cmd.op        = gw_pkg::OP_DFS_USE;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_pend = 1'b1;
                    n_state         = S_DH_W;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_pend = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// File: hw/rtl/gw_dp.sv
module gw_dp #(
    parameter int MAX_VERTICES = gw_pkg::GW_MAX_VERTICES,
    parameter int MAX_EDGES    = gw_pkg::GW_MAX_EDGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gw_pkg::VC_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                i_kind,
    input  logic [gw_pkg::VERT_W-1:0] i_first,
    input  logic [gw_pkg::VERT_W-1:0] i_second,
    input  gw_pkg::t_cmd              i_cmd,
    output gw_pkg::t_stat             o_stat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [gw_pkg::VERT_W-1:0] o_vertex,
    output logic [1:0]                o_status,
    output logic                      o_last
);
    localparam int VW    = gw_pkg::VERT_W;
    localparam int VCW   = gw_pkg::VC_W;
    localparam int ENTRY = 2 * MAX_EDGES;
    localparam int PW    = $clog2(ENTRY + 1);
    localparam int EAW   = $clog2(ENTRY);
    localparam int VIW   = $clog2(MAX_VERTICES);
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int EW    = VW + PW;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRY);

    logic [1:0]              r_kind;
    logic [VW-1:0]           r_a, r_b, r_pend;
    logic [VCW-1:0]          r_vc;
    logic [PW-1:0]           r_used, r_ptr;
    logic [MAX_VERTICES-1:0] r_hvld, r_vis;
    logic                    r_hv_q;
    logic [CW-1:0]           r_front, r_rear, r_top;
    logic                    r_ovalid, r_olast;
    logic [VW-1:0]           r_overt;
    logic [1:0]              r_ostat;

    logic [VIW-1:0] head_raddr, head_waddr;
    logic           head_we;
    logic [PW-1:0]  head_rdata, head_q;
    logic           edge_we;
    logic [EW-1:0]  edge_wdata, edge_rdata;
    logic [VW-1:0]  e_nbr;
    logic [PW-1:0]  e_next;
    logic           q_we;
    logic [VIW-1:0] q_waddr;
    logic [VW-1:0]  q_wdata, q_rdata;
    logic           s_we;
    logic [CW-1:0]  top_m1, top_m2;
    logic [PW-1:0]  s_rdata;
    logic           out_free;
    logic [VW-1:0]  vc_lim;

    assign head_q     = r_hv_q ? head_rdata : NULL_PTR;
    assign e_nbr      = edge_rdata[EW-1:PW];
    assign e_next     = edge_rdata[PW-1:0];
    assign top_m1     = r_top - CW'(1);
    assign top_m2     = r_top - CW'(2);
    assign out_free   = !r_ovalid || i_out_ready;
    assign vc_lim     = VW'(0);

    always_comb begin
        head_raddr = r_a[VIW-1:0];
        case (i_cmd.op)
            gw_pkg::OP_ADD_RD_B:  head_raddr = r_b[VIW-1:0];
            gw_pkg::OP_HEAD_RD_Q: head_raddr = q_rdata[VIW-1:0];
            gw_pkg::OP_DFS_USE:   head_raddr = e_nbr[VIW-1:0];
            default:              head_raddr = r_a[VIW-1:0];
        endcase
    end

    assign head_we    = (i_cmd.op == gw_pkg::OP_ADD_WR_A) || (i_cmd.op == gw_pkg::OP_ADD_WR_B);
    assign head_waddr = (i_cmd.op == gw_pkg::OP_ADD_WR_A) ? r_a[VIW-1:0] : r_b[VIW-1:0];
    assign edge_we    = head_we;
    assign edge_wdata = (i_cmd.op == gw_pkg::OP_ADD_WR_A) ? {r_b, head_q} : {r_a, head_q};

    assign q_we    = (i_cmd.op == gw_pkg::OP_WALK_INIT) ||
                     (i_cmd.op == gw_pkg::OP_BFS_USE && i_cmd.emit);
    assign q_waddr = (i_cmd.op == gw_pkg::OP_WALK_INIT) ? VIW'(0) : r_rear[VIW-1:0];
    assign q_wdata = (i_cmd.op == gw_pkg::OP_WALK_INIT) ? r_a : e_nbr;
    assign s_we    = (i_cmd.op == gw_pkg::OP_DFS_USE) && i_cmd.emit;

    gw_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(r_used),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    gw_ram #(.WIDTH(EW), .DEPTH(ENTRY)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(r_used[EAW-1:0]), .i_wdata(edge_wdata),
        .i_raddr(r_ptr[EAW-1:0]), .o_rdata(edge_rdata)
    );
    gw_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(r_front[VIW-1:0]), .o_rdata(q_rdata)
    );
    gw_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(top_m1[VIW-1:0]), .i_wdata(e_next),
        .i_raddr(top_m2[VIW-1:0]), .o_rdata(s_rdata)
    );

    // status toward the controller
    always_comb begin
        o_stat.kind      = gw_pkg::t_kind'(r_kind);
        o_stat.range_err = ({1'b0, r_a} >= r_vc) ||
                           (r_kind == gw_pkg::K_ADD && ({1'b0, r_b} >= r_vc));
        o_stat.mem_full  = ((PW+1)'(r_used) + (PW+1)'(2)) > (PW+1)'(ENTRY);
        o_stat.q_empty   = (r_front == r_rear) || (r_front >= CW'(MAX_VERTICES));
        o_stat.rear_room = r_rear < CW'(MAX_VERTICES);
        o_stat.top_room  = r_top < CW'(MAX_VERTICES);
        o_stat.top_one   = r_top == CW'(1);
        o_stat.ptr_null  = r_ptr >= NULL_PTR;
        o_stat.nbr_ok    = ({1'b0, e_nbr} < r_vc) && !r_vis[e_nbr[VIW-1:0]];
        o_stat.out_free  = out_free;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc     <= VCW'(MAX_VERTICES);
            r_used   <= '0;
            r_hvld   <= '0;
            r_vis    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) begin
                    r_vc <= VCW'(1);
                end else if (i_cfg_wdata > VCW'(MAX_VERTICES)) begin
                    r_vc <= VCW'(MAX_VERTICES);
                end else begin
                    r_vc <= i_cfg_wdata;
                end
            end
            if (i_cmd.op == gw_pkg::OP_CLEAR) begin
                r_used <= '0;
                r_hvld <= '0;
                r_vis  <= '0;
            end
            if (head_we) begin
                r_used             <= r_used + PW'(1);
                r_hvld[head_waddr] <= 1'b1;
            end
            if (i_cmd.op == gw_pkg::OP_WALK_INIT) begin
                // fresh map with only the start vertex marked
                r_vis <= MAX_VERTICES'(1) << r_a[VIW-1:0];
            end
            if (q_we && i_cmd.op != gw_pkg::OP_WALK_INIT || s_we) begin
                r_vis[e_nbr[VIW-1:0]] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // walk payload registers
    always_ff @(posedge i_clk) begin
        r_hv_q <= r_hvld[head_raddr];
        case (i_cmd.op)
            gw_pkg::OP_LOAD: begin
                r_kind <= i_kind;
                r_a    <= i_first;
                r_b    <= i_second;
            end
            gw_pkg::OP_WALK_INIT: begin
                r_pend  <= r_a;
                r_front <= '0;
                r_rear  <= CW'(1);
                r_top   <= CW'(1);
            end
            gw_pkg::OP_Q_RD:      r_front <= r_front + CW'(1);
            gw_pkg::OP_PTR_HEAD:  r_ptr   <= head_q;
            gw_pkg::OP_PTR_STK:   r_ptr   <= s_rdata;
            gw_pkg::OP_STK_RD:    r_top   <= top_m1;
            gw_pkg::OP_BFS_USE: begin
                r_ptr <= e_next;
                if (i_cmd.emit) begin
                    r_pend <= e_nbr;
                    r_rear <= r_rear + CW'(1);
                end
            end
            gw_pkg::OP_DFS_USE: begin
                r_ptr <= e_next;
                if (i_cmd.emit) begin
                    r_pend <= e_nbr;
                    r_top  <= r_top + CW'(1);
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            r_overt <= i_cmd.emit_pend ? r_pend : vc_lim;
            r_ostat <= i_cmd.emit_stat;
            r_olast <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_vertex    = r_overt;
    assign o_status    = r_ostat;
    assign o_last      = r_olast;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free) else $error("result register overwritten");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == gw_pkg::OP_ADD_WR_A) |=> (r_used == $past(r_used) + PW'(1)))
        else $error("edge count step");
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NULL_PTR) else $error("edge count beyond memory");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == gw_pkg::OP_Q_RD) |-> (r_front < r_rear))
        else $error("queue read past tail");
endmodule

// File: hw/rtl/graph_bfs_dfs_walker_top.sv
// Graph walker: holds an undirected graph as adjacency lists (newest neighbor
// first) and answers four item kinds: clear, add edge, breadth-first walk and
// depth-first walk. Clear and add give one result with last set; a bad vertex
// gives status 2, a full edge memory status 1. A walk returns each reached
// vertex in visiting order, the final one with last set. Items are taken one
// at a time; every step of a walk waits on one registered read of the head,
// edge, queue or stack RAM. The result register lets the walk run one vertex
// ahead of a stalled sink. vertex_count is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while idle, which the block itself does not
// enforce; 0 stores 1 and values above MAX_VERTICES store MAX_VERTICES.
// No clearing pass runs after reset.
module graph_bfs_dfs_walker_top #(
    parameter int MAX_VERTICES = gw_pkg::GW_MAX_VERTICES,
    parameter int MAX_EDGES    = gw_pkg::GW_MAX_EDGES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [gw_pkg::VC_W-1:0] i_cfg_wdata,
    gw_in_if.sink                   i_item,
    gw_out_if.source                o_result
);
    gw_pkg::t_cmd  cmd;
    gw_pkg::t_stat stat;

    // sequencer: one state per memory access of the walk
    gw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_item.valid),
        .o_in_ready(i_item.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // memories, pointers, visited map and the result register
    gw_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_kind     (i_item.kind),
        .i_first    (i_item.first_vertex),
        .i_second   (i_item.second_vertex),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_result.valid),
        .i_out_ready(o_result.ready),
        .o_vertex   (o_result.vertex),
        .o_status   (o_result.status),
        .o_last     (o_result.last)
    );
endmodule
